@@ src/rc_touch_sense_qualifier_defines.svh @@
// Assertion macros for the design file that checks its own logic.
`ifndef RC_TOUCH_SENSE_QUALIFIER_DEFINES_SVH
`define RC_TOUCH_SENSE_QUALIFIER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RCTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RCTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rcts_pkg.sv @@
package rcts_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int SAMPLE_W = 20;
    localparam int TIMEOUT_W = 20;
    localparam int THRESH_W = 20;
    localparam int REQ_W = 4;
    localparam int SETTLE_W = 10;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CMP_W = (COUNT_WIDTH > SAMPLE_W) ? COUNT_WIDTH : SAMPLE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_SAMPLES = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = 2'd3;

    localparam logic [TIMEOUT_W-1:0] RESET_CHARGE_TIMEOUT = 20'd100000;
    localparam logic [THRESH_W-1:0] RESET_TOUCH_THRESHOLD = 20'd20000;
    localparam logic [REQ_W-1:0] RESET_REQUIRED_SAMPLES = 4'd5;
    localparam logic [SETTLE_W-1:0] RESET_SETTLE_TICKS = 10'd10;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CMP_W-1:0] cmp_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] charge_timeout;
        logic [THRESH_W-1:0]  touch_threshold;
        logic [REQ_W-1:0]     required_samples;
        logic [SETTLE_W-1:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic                sense_drive_enable;
        logic                sense_drive_high;
        logic                charge_drive_high;
        logic                sample_done;
        logic [SAMPLE_W-1:0] sample_count;
        logic                sample_in_time;
        logic                sample_touched;
        logic                touch_event;
    } result_t;

endpackage

@@ src/rcts_if.sv @@
interface rcts_in_if;
    logic valid;
    logic ready;
    logic sense_level;

    modport source (output valid, output sense_level, input ready);
    modport sink (input valid, input sense_level, output ready);
endinterface

interface rcts_out_if;
    logic                         valid;
    logic                         ready;
    logic                         sense_drive_enable;
    logic                         sense_drive_high;
    logic                         charge_drive_high;
    logic                         sample_done;
    logic [rcts_pkg::SAMPLE_W-1:0] sample_count;
    logic                         sample_in_time;
    logic                         sample_touched;
    logic                         touch_event;

    modport source (
        output valid, output sense_drive_enable, output sense_drive_high,
        output charge_drive_high, output sample_done, output sample_count,
        output sample_in_time, output sample_touched, output touch_event,
        input ready
    );
    modport sink (
        input valid, input sense_drive_enable, input sense_drive_high,
        input charge_drive_high, input sample_done, input sample_count,
        input sample_in_time, input sample_touched, input touch_event,
        output ready
    );
endinterface

@@ src/rc_touch_sense_qualifier.sv @@
// RC charge-time touch qualifier.
// The sense channel delivers one sense_level sample per transfer, normally one
// per clock tick. Each transfer produces exactly one transfer on the result
// channel, carrying the pin drives of the current phase together with the
// sample status fields of a measurement cycle that completes on that tick.
// The work for one sample is done in the cycle it is accepted; its result is
// held in an output register and is offered in the next cycle.
// Throughput is one sample per cycle: a new sample is accepted whenever the
// output register is empty or its result is taken in the same cycle.
// When the receiver stalls, the held result stays stable and further samples
// wait, so the phase sequencer advances only on accepted samples.
// Registers are written through cfg_we, cfg_index and cfg_data, one per cycle.
// Reset loads the register defaults, returns the sequencer to the discharge
// settle phase with cleared counters and empties the output register.
`include "rc_touch_sense_qualifier_defines.svh"

module rc_touch_sense_qualifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rcts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcts_pkg::CFG_DATA_W-1:0]  cfg_data,
    rcts_in_if.sink                          sense,
    rcts_out_if.source                       result
);

    rcts_pkg::cfg_t    cfg;
    rcts_pkg::result_t core_result;
    rcts_pkg::result_t held;
    logic              can_load;
    logic              step;
    logic              held_valid;

    assign sense.ready = can_load;
    assign step = sense.valid && can_load;

    rcts_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    rcts_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (step),
        .sense_level (sense.sense_level),
        .result      (core_result)
    );

    rcts_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .data     (core_result),
        .take     (result.ready),
        .can_load (can_load),
        .valid    (held_valid),
        .q        (held)
    );

    assign result.valid = held_valid;
    assign result.sense_drive_enable = held.sense_drive_enable;
    assign result.sense_drive_high = held.sense_drive_high;
    assign result.charge_drive_high = held.charge_drive_high;
    assign result.sample_done = held.sample_done;
    assign result.sample_count = held.sample_count;
    assign result.sample_in_time = held.sample_in_time;
    assign result.sample_touched = held.sample_touched;
    assign result.touch_event = held.touch_event;

    `RCTS_ASSERT_NEXT(a_accept_gives_result, sense.valid && sense.ready, result.valid, "accepted sample left no result")
    `RCTS_ASSERT_SAME(a_event_needs_touch, result.valid && result.touch_event, result.sample_done && result.sample_touched, "touch event without a touched sample")
    `RCTS_ASSERT_SAME(a_done_pins_released, result.valid && result.sample_done, !result.sense_drive_enable && !result.charge_drive_high, "sample completed outside the discharge count phase")

endmodule

@@ src/rcts_cfg_regs.sv @@
module rcts_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [rcts_pkg::CFG_INDEX_W-1:0] index,
    input  logic [rcts_pkg::CFG_DATA_W-1:0]  data,
    output rcts_pkg::cfg_t                   cfg
);

    rcts_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_timeout <= rcts_pkg::RESET_CHARGE_TIMEOUT;
            cfg_reg.touch_threshold <= rcts_pkg::RESET_TOUCH_THRESHOLD;
            cfg_reg.required_samples <= rcts_pkg::RESET_REQUIRED_SAMPLES;
            cfg_reg.settle_ticks <= rcts_pkg::RESET_SETTLE_TICKS;
        end
        else if (we)
        begin
            unique case (index)
                rcts_pkg::REG_CHARGE_TIMEOUT:
                    cfg_reg.charge_timeout <= data[rcts_pkg::TIMEOUT_W-1:0];
                rcts_pkg::REG_TOUCH_THRESHOLD:
                    cfg_reg.touch_threshold <= data[rcts_pkg::THRESH_W-1:0];
                rcts_pkg::REG_REQUIRED_SAMPLES:
                    cfg_reg.required_samples <= data[rcts_pkg::REQ_W-1:0];
                rcts_pkg::REG_SETTLE_TICKS:
                    cfg_reg.settle_ticks <= data[rcts_pkg::SETTLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/rcts_core.sv @@
module rcts_core (
    input  logic               clk,
    input  logic               rst_n,
    input  rcts_pkg::cfg_t     cfg,
    input  logic               step,
    input  logic               sense_level,
    output rcts_pkg::result_t  result
);

    localparam logic [1:0] PH_DIS_SETTLE = 2'd0;
    localparam logic [1:0] PH_CHG_COUNT = 2'd1;
    localparam logic [1:0] PH_CHG_SETTLE = 2'd2;
    localparam logic [1:0] PH_DIS_COUNT = 2'd3;

    logic [1:0]                   phase_reg;
    logic [1:0]                   phase_next;
    rcts_pkg::count_t             cycle_count_reg;
    rcts_pkg::count_t             cycle_count_next;
    logic [rcts_pkg::SETTLE_W-1:0] settle_count_reg;
    logic [rcts_pkg::SETTLE_W-1:0] settle_count_next;
    logic [rcts_pkg::REQ_W-1:0]    touch_run_reg;
    logic [rcts_pkg::REQ_W-1:0]    touch_run_next;

    rcts_pkg::cmp_t count_ext;
    logic           below_timeout;
    logic           below_top;
    logic           may_count;
    logic           settle_done;
    logic           below_threshold;
    logic           run_done;

    assign count_ext = rcts_pkg::CMP_W'(cycle_count_reg);
    assign below_timeout = count_ext < rcts_pkg::CMP_W'(cfg.charge_timeout);
    assign below_top = ~&cycle_count_reg;
    assign may_count = below_timeout && below_top;
    assign settle_done = ({1'b0, settle_count_reg} + 11'd1) >= {1'b0, cfg.settle_ticks};
    assign below_threshold = count_ext < rcts_pkg::CMP_W'(cfg.touch_threshold);
    assign run_done = ({1'b0, touch_run_reg} + 5'd1) >= {1'b0, cfg.required_samples};

    always_comb
    begin
        phase_next = phase_reg;
        cycle_count_next = cycle_count_reg;
        settle_count_next = settle_count_reg;
        touch_run_next = touch_run_reg;
        result = '0;
        unique case (phase_reg)
            PH_DIS_SETTLE:
            begin
                result.sense_drive_enable = 1'b1;
                if (settle_done)
                begin
                    settle_count_next = '0;
                    phase_next = PH_CHG_COUNT;
                end
                else
                begin
                    settle_count_next = settle_count_reg + 1'b1;
                end
            end
            PH_CHG_COUNT:
            begin
                result.charge_drive_high = 1'b1;
                if (!sense_level && may_count)
                begin
                    cycle_count_next = cycle_count_reg + 1'b1;
                end
                else
                begin
                    settle_count_next = '0;
                    phase_next = PH_CHG_SETTLE;
                end
            end
            PH_CHG_SETTLE:
            begin
                result.sense_drive_enable = 1'b1;
                result.sense_drive_high = 1'b1;
                result.charge_drive_high = 1'b1;
                if (settle_done)
                begin
                    settle_count_next = '0;
                    phase_next = PH_DIS_COUNT;
                end
                else
                begin
                    settle_count_next = settle_count_reg + 1'b1;
                end
            end
            PH_DIS_COUNT:
            begin
                if (sense_level && may_count)
                begin
                    cycle_count_next = cycle_count_reg + 1'b1;
                end
                else
                begin
                    result.sample_done = 1'b1;
                    result.sample_count = rcts_pkg::SAMPLE_W'(count_ext);
                    result.sample_in_time = below_timeout;
                    result.sample_touched = below_threshold;
                    if (below_threshold)
                    begin
                        if (run_done)
                        begin
                            result.touch_event = 1'b1;
                            touch_run_next = '0;
                        end
                        else
                        begin
                            touch_run_next = touch_run_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        touch_run_next = '0;
                    end
                    cycle_count_next = '0;
                    settle_count_next = '0;
                    phase_next = PH_DIS_SETTLE;
                end
            end
            default:
            begin
                phase_next = PH_DIS_SETTLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DIS_SETTLE;
            cycle_count_reg <= '0;
            settle_count_reg <= '0;
            touch_run_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cycle_count_reg <= cycle_count_next;
            settle_count_reg <= settle_count_next;
            touch_run_reg <= touch_run_next;
        end
    end

endmodule

@@ src/rcts_out_reg.sv @@
module rcts_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rcts_pkg::result_t data,
    input  logic              take,
    output logic              can_load,
    output logic              valid,
    output rcts_pkg::result_t q
);

    logic              valid_reg;
    rcts_pkg::result_t data_reg;

    assign can_load = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign valid = valid_reg;
    assign q = data_reg;

endmodule
